// ===== rtl/floor_point_classify_project_unit_defines.svh =====
// Assertion macros shared by the floor point classifier RTL.
`ifndef FLOOR_POINT_CLASSIFY_PROJECT_UNIT_DEFINES_SVH
`define FLOOR_POINT_CLASSIFY_PROJECT_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FPC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("floor classifier check failed");

// next-cycle implication, disabled in reset
`define FPC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("floor classifier check failed");

`endif

// ===== rtl/fpc_pkg.sv =====
// Shared types, constants and helpers of the floor point classifier.
package fpc_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 14;
   localparam int CFG_W          = 16;
   localparam int LIFT_W         = 10;
   localparam int CSR_IDX_W      = 3;
   localparam int LIFT_PROD_W    = CFG_W + LIFT_W + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_NORMAL_X  = 3'd0,
      REG_NORMAL_Y  = 3'd1,
      REG_NORMAL_Z  = 3'd2,
      REG_OFFSET    = 3'd3,
      REG_THRESHOLD = 3'd4,
      REG_LIFT      = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic signed [CFG_W-1:0] normal_x;
      logic signed [CFG_W-1:0] normal_y;
      logic signed [CFG_W-1:0] normal_z;
      logic signed [CFG_W-1:0] plane_offset;
      logic signed [CFG_W-1:0] floor_limit;
      logic [LIFT_W-1:0]       lift_mm;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      normal_x:     16'sd0,
      normal_y:     16'sd0,
      normal_z:     16'sd16384,
      plane_offset: 16'sd0,
      floor_limit:  -16'sd50,
      lift_mm:      10'd110
   };

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

// ===== rtl/fpc_ifs.sv =====
// Valid/ready channel interfaces for point requests and classified responses.
interface fpc_req_if #(parameter int COORD_BITS = fpc_pkg::COORD_BITS_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic signed [COORD_BITS-1:0] point_z;
   logic                         last_in_cloud;

   modport source(output valid, point_x, point_y, point_z, last_in_cloud, input ready);
   modport sink(input valid, point_x, point_y, point_z, last_in_cloud, output ready);
endinterface

interface fpc_rsp_if #(parameter int COORD_BITS = fpc_pkg::COORD_BITS_DEF);
   logic                         valid;
   logic                         ready;
   logic                         point_class;
   logic signed [COORD_BITS-1:0] out_x;
   logic signed [COORD_BITS-1:0] out_y;
   logic signed [COORD_BITS-1:0] out_z;
   logic                         last_out;

   modport source(output valid, point_class, out_x, out_y, out_z, last_out, input ready);
   modport sink(input valid, point_class, out_x, out_y, out_z, last_out, output ready);
endinterface

// ===== rtl/floor_point_classify_project_unit.sv =====
// Top level of the floor point classifier: config registers, pipeline and channels.
`include "floor_point_classify_project_unit_defines.svh"

// Classifies one 3D point per clock as floor or obstacle against a configured plane and
// replaces floor points by their ray/plane intersection lifted along the normal. Most of the
// pipeline depth comes from the restoring divider, which resolves one quotient bit per stage
// in three parallel lanes. Sustained rate is one transaction per cycle. The whole pipeline
// holds while a response waits at the output, so req ready follows rsp ready when the output
// register is full.
// Configuration writes take effect on the next cycle and must be made with the pipe empty.
module floor_point_classify_project_unit #(
   parameter int COORD_BITS       = fpc_pkg::COORD_BITS_DEF,
   parameter int NORMAL_FRAC_BITS = fpc_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   fpc_req_if.sink                         req_ch,
   fpc_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [fpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fpc_pkg::CFG_W-1:0]       csr_wdata
);
   localparam int P      = COORD_BITS;
   localparam int F      = NORMAL_FRAC_BITS;
   localparam int BW     = P + 17;
   localparam int AW     = P + 16;
   localparam int QB     = P + F + 2;
   localparam int LTW    = 27 - F;
   localparam int SIDE_W = 8 + 3 * LTW + 3 * P;

   fpc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (fpc_pkg::csr_reg_type'(csr_index))
            fpc_pkg::REG_NORMAL_X:  cfg_in.normal_x     = csr_wdata;
            fpc_pkg::REG_NORMAL_Y:  cfg_in.normal_y     = csr_wdata;
            fpc_pkg::REG_NORMAL_Z:  cfg_in.normal_z     = csr_wdata;
            fpc_pkg::REG_OFFSET:    cfg_in.plane_offset = csr_wdata;
            fpc_pkg::REG_THRESHOLD: cfg_in.floor_limit  = csr_wdata;
            fpc_pkg::REG_LIFT:      cfg_in.lift_mm      = csr_wdata[fpc_pkg::LIFT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= fpc_pkg::CFG_RESET;
      else cfg_ff <= cfg_in;
   end

   logic en;
   assign en           = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = en;

   logic signed [P-1:0] in_p [3];
   assign in_p[0] = req_ch.point_x;
   assign in_p[1] = req_ch.point_y;
   assign in_p[2] = req_ch.point_z;

   logic                  f_valid, f_floor, f_last;
   logic signed [P-1:0]   f_p [3];
   logic [BW-1:0]         f_b;
   logic [AW-1:0]         f_a [3];
   logic [2:0]            f_sat, f_neg;
   logic signed [LTW-1:0] f_t2 [3];

   fpc_front #(.COORD_BITS(P), .NORMAL_FRAC_BITS(F)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (req_ch.valid),
      .in_p      (in_p),
      .in_last   (req_ch.last_in_cloud),
      .out_valid (f_valid),
      .out_floor (f_floor),
      .out_last  (f_last),
      .out_p     (f_p),
      .out_b     (f_b),
      .out_a     (f_a),
      .out_sat   (f_sat),
      .out_neg   (f_neg),
      .out_t2    (f_t2)
   );

   logic [SIDE_W-1:0]     side_in, side_out;
   logic                  d_valid, d_floor, d_last;
   logic [QB-1:0]         d_quo [3];
   logic [2:0]            d_sat, d_neg;
   logic signed [LTW-1:0] d_t2 [3];
   logic signed [P-1:0]   d_p [3];

   assign side_in = {f_floor, f_last, f_sat, f_neg, f_t2[2], f_t2[1], f_t2[0],
                     f_p[2], f_p[1], f_p[0]};
   assign {d_floor, d_last, d_sat, d_neg, d_t2[2], d_t2[1], d_t2[0],
           d_p[2], d_p[1], d_p[0]} = side_out;

   fpc_divide #(.COORD_BITS(P), .NORMAL_FRAC_BITS(F), .SIDE_W(SIDE_W)) u_divide (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_b      (f_b),
      .in_a      (f_a),
      .in_side   (side_in),
      .out_valid (d_valid),
      .out_quo   (d_quo),
      .out_side  (side_out)
   );

   logic signed [P-1:0] b_c [3];

   fpc_back #(.COORD_BITS(P), .NORMAL_FRAC_BITS(F)) u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .in_quo    (d_quo),
      .in_floor  (d_floor),
      .in_last   (d_last),
      .in_sat    (d_sat),
      .in_neg    (d_neg),
      .in_t2     (d_t2),
      .in_p      (d_p),
      .out_valid (rsp_ch.valid),
      .out_class (rsp_ch.point_class),
      .out_last  (rsp_ch.last_out),
      .out_c     (b_c)
   );

   assign rsp_ch.out_x = b_c[0];
   assign rsp_ch.out_y = b_c[1];
   assign rsp_ch.out_z = b_c[2];

   `FPC_ASSERT_NOW(a_ready_when_out_empty, !rsp_ch.valid, req_ch.ready)
   `FPC_ASSERT_NOW(a_no_accept_on_stall, rsp_ch.valid && !rsp_ch.ready, !req_ch.ready)
   `FPC_ASSERT_NEXT(a_lift_write, csr_we && (csr_index == fpc_pkg::REG_LIFT), cfg_ff.lift_mm == $past(csr_wdata[fpc_pkg::LIFT_W-1:0]))

endmodule

// ===== rtl/fpc_front.sv =====
// Front pipeline: products, plane distance, floor decision and divider operands.
module fpc_front #(
   parameter int COORD_BITS       = fpc_pkg::COORD_BITS_DEF,
   parameter int NORMAL_FRAC_BITS = fpc_pkg::FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  fpc_pkg::cfg_type       cfg,
   input  logic                   in_valid,
   input  logic signed [COORD_BITS-1:0] in_p [3],
   input  logic                   in_last,
   output logic                   out_valid,
   output logic                   out_floor,
   output logic                   out_last,
   output logic signed [COORD_BITS-1:0] out_p [3],
   output logic [COORD_BITS+16:0] out_b,
   output logic [COORD_BITS+15:0] out_a [3],
   output logic [2:0]             out_sat,
   output logic [2:0]             out_neg,
   output logic signed [26-NORMAL_FRAC_BITS:0] out_t2 [3]
);
   localparam int P    = COORD_BITS;
   localparam int F    = NORMAL_FRAC_BITS;
   localparam int CW   = fpc_pkg::CFG_W;
   localparam int MW   = CW + P;
   localparam int DW   = MW + 2;
   localparam int AW   = CW + P;
   localparam int BW   = P + 17;
   localparam int LPW  = fpc_pkg::LIFT_PROD_W;
   localparam int LTW  = 27 - F;
   localparam int XW   = fpc_pkg::max_int(DW, CW + F) + 1;
   localparam int SCW  = BW + P + 1;

   logic signed [CW-1:0] nvec [3];
   logic [CW-1:0]        dmag;
   logic                 dneg;

   assign nvec[0] = cfg.normal_x;
   assign nvec[1] = cfg.normal_y;
   assign nvec[2] = cfg.normal_z;
   assign dneg    = cfg.plane_offset[CW-1];
   assign dmag    = dneg ? CW'(-cfg.plane_offset) : CW'(cfg.plane_offset);

   // stage 1: input register
   logic                 v1_ff, last1_ff;
   logic signed [P-1:0]  p1_ff [3];

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= in_valid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff    <= in_p;
         last1_ff <= in_last;
      end
   end

   // stage 2: multiplies
   logic                  v2_ff, last2_ff;
   logic signed [P-1:0]   p2_ff [3];
   logic signed [MW-1:0]  prod2_ff [3], prod2_in [3];
   logic [AW-1:0]         ap2_ff [3], ap2_in [3];
   logic signed [LPW-1:0] lp2_ff [3], lp2_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [P-1:0] pm;
         pm = p1_ff[i][P-1] ? P'(-p1_ff[i]) : P'(p1_ff[i]);
         prod2_in[i] = MW'(nvec[i]) * MW'(p1_ff[i]);
         ap2_in[i]   = AW'(dmag) * AW'(pm);
         lp2_in[i]   = LPW'(nvec[i]) * $signed({1'b0, cfg.lift_mm});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         p2_ff    <= p1_ff;
         last2_ff <= last1_ff;
         prod2_ff <= prod2_in;
         ap2_ff   <= ap2_in;
         lp2_ff   <= lp2_in;
      end
   end

   // stage 3: dot product and rounded lift
   logic                  v3_ff, last3_ff;
   logic signed [P-1:0]   p3_ff [3];
   logic [AW-1:0]         ap3_ff [3];
   logic signed [DW-1:0]  dot3_ff, dot3_in;
   logic signed [LTW-1:0] t23_ff [3], t23_in [3];

   always_comb begin
      dot3_in = DW'(prod2_ff[0]) + DW'(prod2_ff[1]) + DW'(prod2_ff[2]);
      for (int i = 0; i < 3; i++) begin
         logic [LPW-1:0]   lm, rnd;
         logic [LTW-2:0]   m;
         lm  = lp2_ff[i][LPW-1] ? LPW'(-lp2_ff[i]) : LPW'(lp2_ff[i]);
         rnd = lm + (LPW'(1) << (F - 1));
         m   = rnd[F +: LTW-1];
         t23_in[i] = lp2_ff[i][LPW-1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         p3_ff    <= p2_ff;
         last3_ff <= last2_ff;
         ap3_ff   <= ap2_ff;
         dot3_ff  <= dot3_in;
         t23_ff   <= t23_in;
      end
   end

   // stage 4: floor decision, divisor, quotient overflow
   logic                 v4_ff, floor4_ff, floor4_in, last4_ff;
   logic signed [P-1:0]  p4_ff [3];
   logic [AW-1:0]        ap4_ff [3];
   logic [BW-1:0]        b4_ff, b4_in;
   logic [2:0]           sat4_ff, sat4_in, neg4_ff, neg4_in;
   logic signed [LTW-1:0] t24_ff [3];
   logic signed [XW-1:0] plane_dist, thr;

   always_comb begin
      plane_dist = XW'(dot3_ff) + (XW'(cfg.plane_offset) <<< F);
      thr        = XW'(cfg.floor_limit) <<< F;
      floor4_in  = (plane_dist < thr) && (dot3_ff != '0);
      b4_in      = dot3_ff[DW-1] ? BW'(-dot3_ff) : BW'(dot3_ff);
      for (int i = 0; i < 3; i++) begin
         sat4_in[i] = SCW'(ap3_ff[i]) >= (SCW'(b4_in) << (P + 1));
         neg4_in[i] = !(dneg ^ p3_ff[i][P-1] ^ dot3_ff[DW-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (en) v4_ff <= v3_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         p4_ff     <= p3_ff;
         last4_ff  <= last3_ff;
         ap4_ff    <= ap3_ff;
         floor4_ff <= floor4_in;
         b4_ff     <= b4_in;
         sat4_ff   <= sat4_in;
         neg4_ff   <= neg4_in;
         t24_ff    <= t23_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_floor = floor4_ff;
   assign out_last  = last4_ff;
   assign out_p     = p4_ff;
   assign out_b     = b4_ff;
   assign out_a     = ap4_ff;
   assign out_sat   = sat4_ff;
   assign out_neg   = neg4_ff;
   assign out_t2    = t24_ff;

endmodule

// ===== rtl/fpc_divide.sv =====
// Pipelined restoring divider: three lanes sharing one divisor, one quotient bit per stage.
module fpc_divide #(
   parameter int COORD_BITS       = fpc_pkg::COORD_BITS_DEF,
   parameter int NORMAL_FRAC_BITS = fpc_pkg::FRAC_BITS_DEF,
   parameter int SIDE_W           = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [COORD_BITS+16:0] in_b,
   input  logic [COORD_BITS+15:0] in_a [3],
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic [COORD_BITS+NORMAL_FRAC_BITS+1:0] out_quo [3],
   output logic [SIDE_W-1:0]    out_side
);
   localparam int P  = COORD_BITS;
   localparam int F  = NORMAL_FRAC_BITS;
   localparam int BW = P + 17;
   localparam int QB = P + F + 2;

   logic              valid_ff [QB];
   logic [BW-1:0]     b_ff [QB];
   logic [SIDE_W-1:0] side_ff [QB];
   logic [BW-1:0]     rem_ff [3][QB];
   logic [QB-1:0]     dvd_ff [3][QB];
   logic [QB-1:0]     quo_ff [3][QB];

   for (genvar s = 0; s < QB; s++) begin : g_stage
      logic              v_src;
      logic [BW-1:0]     b_src;
      logic [SIDE_W-1:0] side_src;

      if (s == 0) begin : g_first
         assign v_src    = in_valid;
         assign b_src    = in_b;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = valid_ff[s-1];
         assign b_src    = b_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (reset) valid_ff[s] <= 1'b0;
         else if (en) valid_ff[s] <= v_src;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            b_ff[s]    <= b_src;
            side_ff[s] <= side_src;
         end
      end

      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic [BW-1:0] rem_src, rem_in;
         logic [QB-1:0] dvd_src, quo_src, dvd_in, quo_in;
         logic [BW:0]   shifted;
         logic [BW+1:0] trial;
         logic          fits;

         if (s == 0) begin : g_first
            // high dividend bits preload the remainder; no overflow keeps it below the divisor
            assign rem_src = BW'(in_a[l] >> (P + 1));
            assign dvd_src = {in_a[l][P:0], {(F + 1){1'b0}}};
            assign quo_src = '0;
         end else begin : g_next
            assign rem_src = rem_ff[l][s-1];
            assign dvd_src = dvd_ff[l][s-1];
            assign quo_src = quo_ff[l][s-1];
         end

         assign shifted = {rem_src, dvd_src[QB-1]};
         assign trial   = {1'b0, shifted} - {2'b00, b_src};
         assign fits    = !trial[BW+1];
         assign rem_in  = fits ? trial[BW-1:0] : shifted[BW-1:0];
         assign dvd_in  = dvd_src << 1;
         assign quo_in  = {quo_src[QB-2:0], fits};

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[l][s] <= rem_in;
               dvd_ff[l][s] <= dvd_in;
               quo_ff[l][s] <= quo_in;
            end
         end
      end
   end

   assign out_valid  = valid_ff[QB-1];
   assign out_side   = side_ff[QB-1];
   assign out_quo[0] = quo_ff[0][QB-1];
   assign out_quo[1] = quo_ff[1][QB-1];
   assign out_quo[2] = quo_ff[2][QB-1];

endmodule

// ===== rtl/fpc_back.sv =====
// Back pipeline: quotient rounding and clamp, lift add, saturation and output register.
module fpc_back #(
   parameter int COORD_BITS       = fpc_pkg::COORD_BITS_DEF,
   parameter int NORMAL_FRAC_BITS = fpc_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [COORD_BITS+NORMAL_FRAC_BITS+1:0] in_quo [3],
   input  logic                 in_floor,
   input  logic                 in_last,
   input  logic [2:0]           in_sat,
   input  logic [2:0]           in_neg,
   input  logic signed [26-NORMAL_FRAC_BITS:0] in_t2 [3],
   input  logic signed [COORD_BITS-1:0] in_p [3],
   output logic                 out_valid,
   output logic                 out_class,
   output logic                 out_last,
   output logic signed [COORD_BITS-1:0] out_c [3]
);
   localparam int P   = COORD_BITS;
   localparam int F   = NORMAL_FRAC_BITS;
   localparam int QB  = P + F + 2;
   localparam int LTW = 27 - F;
   localparam int TW  = P + 3;
   localparam int SW  = fpc_pkg::max_int(TW, LTW) + 1;
   localparam logic [QB-1:0] LIMIT = QB'(1) << (P + 1);
   localparam logic signed [SW-1:0] SAT_HI = {{(SW - P + 1){1'b0}}, {(P - 1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

   // stage 1: round, clamp and sign the ray term
   logic                  v1_ff, floor1_ff, last1_ff;
   logic signed [TW-1:0]  t1_ff [3], t1_in [3];
   logic signed [LTW-1:0] t2_ff [3];
   logic signed [P-1:0]   p1_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [QB:0]   inc;
         logic [QB-1:0] qr;
         logic [P+1:0]  tm;
         inc = {1'b0, in_quo[i]} + (QB + 1)'(1);
         qr  = inc[QB:1];
         tm  = (in_sat[i] || (qr > LIMIT)) ? LIMIT[P+1:0] : qr[P+1:0];
         t1_in[i] = in_neg[i] ? -$signed({1'b0, tm}) : $signed({1'b0, tm});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= in_valid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff     <= t1_in;
         t2_ff     <= in_t2;
         p1_ff     <= in_p;
         floor1_ff <= in_floor;
         last1_ff  <= in_last;
      end
   end

   // stage 2: sum, saturate, select; output register
   logic                v2_ff, class2_ff, last2_ff;
   logic signed [P-1:0] c2_ff [3], c2_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [SW-1:0] sum;
         logic signed [SW-1:0] clip;
         sum  = SW'(t1_ff[i]) + SW'(t2_ff[i]);
         clip = (sum > SAT_HI) ? SAT_HI : ((sum < SAT_LO) ? SAT_LO : sum);
         c2_in[i] = floor1_ff ? clip[P-1:0] : p1_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         c2_ff     <= c2_in;
         class2_ff <= floor1_ff;
         last2_ff  <= last1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_class = class2_ff;
   assign out_last  = last2_ff;
   assign out_c     = c2_ff;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the floor point classifier: directed and random points.
module tb;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic               last;
   } point_type;

   typedef struct packed {
      logic               cls;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic               last;
   } class_pt_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [fpc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [fpc_pkg::CFG_W-1:0] csr_wdata;

   fpc_req_if req_ch();
   fpc_rsp_if rsp_ch();

   floor_point_classify_project_unit u_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   fpc_pkg::cfg_type plane_cfg;
   point_type        pending_pts[$];
   class_pt_type     expected_pts[$];
   int               sent_count;
   int               err_count;
   int               sender_idle_pct;
   int               rcv_stall_pct;
   int               hold_left;
   bit               hold_done;

   always #5 clock = ~clock;

   // -(d * p * 2^14) / dot, round half away from zero, magnitude clamped to 2^17
   function automatic longint ray_offset(longint d, longint pv, longint dot);
      longint unsigned a, b, q, r, lim;
      bit neg;
      a = longint'(d < 0 ? -d : d) * longint'(pv < 0 ? -pv : pv);
      b = (dot < 0) ? -dot : dot;
      lim = 64'd1 << 17;
      q = a / b;
      r = a % b;
      if (q >= lim) begin
         q = lim;
      end else begin
         for (int i = 0; i < 14; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= b) begin
               r = r - b;
               q = q | 64'd1;
            end
         end
         r = r << 1;
         if (r >= b) q = q + 64'd1;
         if (q > lim) q = lim;
      end
      neg = !(((d < 0) != (pv < 0)) != (dot < 0));
      if (a == 0) return 0;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint lift_offset(longint n, longint lift);
      longint prod;
      longint unsigned m;
      prod = n * lift;
      m = (longint'(prod < 0 ? -prod : prod) + 8192) >> 14;
      return (prod < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic signed [15:0] sat16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic class_pt_type classify_point(fpc_pkg::cfg_type c, point_type p);
      longint px, py, pz, nx, ny, nz, d, dot, lift;
      class_pt_type res;
      px = longint'(p.x); py = longint'(p.y); pz = longint'(p.z);
      nx = longint'(c.normal_x); ny = longint'(c.normal_y); nz = longint'(c.normal_z);
      d = longint'(c.plane_offset);
      lift = longint'(c.lift_mm);
      dot = nx * px + ny * py + nz * pz;
      res.last = p.last;
      if ((dot + d * 16384 < longint'(c.floor_limit) * 16384) && dot != 0) begin
         res.cls = 1'b1;
         res.x = sat16(ray_offset(d, px, dot) + lift_offset(nx, lift));
         res.y = sat16(ray_offset(d, py, dot) + lift_offset(ny, lift));
         res.z = sat16(ray_offset(d, pz, dot) + lift_offset(nz, lift));
      end else begin
         res.cls = 1'b0;
         res.x = p.x;
         res.y = p.y;
         res.z = p.z;
      end
      return res;
   endfunction

   function automatic point_type rand_point();
      point_type p;
      if ($urandom_range(9) < 6) begin
         p.x = 16'($urandom_range(8000) - 4000);
         p.y = 16'($urandom_range(8000) - 4000);
         p.z = 16'($urandom_range(6000) - 3000);
      end else begin
         p.x = 16'($urandom);
         p.y = 16'($urandom);
         p.z = 16'($urandom);
      end
      p.last = ($urandom_range(7) == 0);
      return p;
   endfunction

   task automatic add_point(point_type p);
      pending_pts.insert(pending_pts.size(), p);
   endtask

   // driver
   always @(posedge clock) begin : drive_proc
      point_type item, seen;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            seen.x = req_ch.point_x;
            seen.y = req_ch.point_y;
            seen.z = req_ch.point_z;
            seen.last = req_ch.last_in_cloud;
            expected_pts.insert(expected_pts.size(), classify_point(plane_cfg, seen));
            sent_count <= sent_count + 1;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_pts.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               item = pending_pts.pop_front();
               req_ch.point_x <= item.x;
               req_ch.point_y <= item.y;
               req_ch.point_z <= item.z;
               req_ch.last_in_cloud <= item.last;
               req_ch.valid <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off so the pipe fills and backs up
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && sent_count >= 300) begin
         hold_left <= 400;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= rcv_stall_pct);
   end

   // monitor
   always @(posedge clock) begin : check_proc
      class_pt_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.cls  = rsp_ch.point_class;
         got.x    = rsp_ch.out_x;
         got.y    = rsp_ch.out_y;
         got.z    = rsp_ch.out_z;
         got.last = rsp_ch.last_out;
         if (expected_pts.size() == 0) begin
            err_count++;
            if (err_count <= 10) $display("unexpected transaction: %p", got);
         end else begin
            want = expected_pts.pop_front();
            if (got.cls !== want.cls || got.x !== want.x || got.y !== want.y ||
                got.z !== want.z || got.last !== want.last) begin
               err_count++;
               if (err_count <= 10)
                  $display("mismatch: exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                     want.cls, want.x, want.y, want.z, want.last,
                     got.cls, got.x, got.y, got.z, got.last);
            end
         end
      end
   end

   task automatic wait_drained();
      do begin
         while (pending_pts.size() != 0 || req_ch.valid || expected_pts.size() != 0)
            @(posedge clock);
         repeat (45) @(posedge clock);
      end while (pending_pts.size() != 0 || req_ch.valid || expected_pts.size() != 0);
   endtask

   task automatic write_cfg(fpc_pkg::cfg_type c);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= fpc_pkg::REG_NORMAL_X;  csr_wdata <= c.normal_x;
      @(posedge clock);
      csr_index <= fpc_pkg::REG_NORMAL_Y;  csr_wdata <= c.normal_y;
      @(posedge clock);
      csr_index <= fpc_pkg::REG_NORMAL_Z;  csr_wdata <= c.normal_z;
      @(posedge clock);
      csr_index <= fpc_pkg::REG_OFFSET;    csr_wdata <= c.plane_offset;
      @(posedge clock);
      csr_index <= fpc_pkg::REG_THRESHOLD; csr_wdata <= c.floor_limit;
      @(posedge clock);
      csr_index <= fpc_pkg::REG_LIFT;      csr_wdata <= {6'd0, c.lift_mm};
      @(posedge clock);
      csr_we <= 1'b0;
      plane_cfg = c;
      @(posedge clock);
   endtask

   initial begin
      fpc_pkg::cfg_type fixed_cfgs[4];
      fpc_pkg::cfg_type c;
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = fpc_pkg::REG_NORMAL_X;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.point_x = '0;
      req_ch.point_y = '0;
      req_ch.point_z = '0;
      req_ch.last_in_cloud = 1'b0;
      rsp_ch.ready = 1'b0;
      sent_count = 0;
      err_count = 0;
      sender_idle_pct = 0;
      rcv_stall_pct = 0;
      plane_cfg = fpc_pkg::CFG_RESET;

      fixed_cfgs[0] = '{16'sd0, 16'sd0, 16'sd16384, 16'sd1000, -16'sd50, 10'd110};
      fixed_cfgs[1] = '{16'sd0, -16'sd11585, 16'sd11585, 16'sd800, -16'sd30, 10'd50};
      fixed_cfgs[2] = '{-16'sd32768, 16'sd32767, -16'sd16384, -16'sd32768, -16'sd32768,
                        10'd1023};
      fixed_cfgs[3] = '{16'sd16384, 16'sd0, 16'sd0, 16'sd32767, 16'sd0, 10'd0};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset config, zero plane constant: floor points collapse to n * lift
      add_point('{16'sd32767, 16'sd32767, 16'sd32767, 1'b0});
      add_point('{-16'sd32768, -16'sd32768, -16'sd32768, 1'b1});
      add_point('{16'sd0, 16'sd0, 16'sd0, 1'b0});
      add_point('{16'sd100, -16'sd200, -16'sd100, 1'b0});
      add_point('{16'sd5, 16'sd5, -16'sd50, 1'b0});
      add_point('{16'sd5, 16'sd5, -16'sd51, 1'b1});
      add_point('{-16'sd1, 16'sd1, -16'sd1, 1'b0});
      wait_drained();

      // negative offset: ray parallel to plane and huge quotients
      write_cfg('{16'sd0, 16'sd0, 16'sd16384, -16'sd1000, -16'sd50, 10'd110});
      add_point('{16'sd1000, 16'sd2000, 16'sd0, 1'b0});
      add_point('{-16'sd32768, 16'sd32767, 16'sd0, 1'b1});
      add_point('{16'sd30000, -16'sd30000, 16'sd1, 1'b0});
      add_point('{-16'sd32768, 16'sd32767, -16'sd1, 1'b0});
      add_point('{16'sd100, 16'sd100, 16'sd949, 1'b0});
      add_point('{16'sd100, 16'sd100, 16'sd950, 1'b1});
      add_point('{16'sd3, -16'sd3, 16'sd2, 1'b0});
      wait_drained();

      write_cfg(fixed_cfgs[2]);
      add_point('{16'sd32767, -16'sd32768, 16'sd32767, 1'b0});
      add_point('{-16'sd32768, 16'sd32767, -16'sd32768, 1'b1});
      add_point('{16'sd1, 16'sd1, 16'sd1, 1'b0});
      add_point('{16'sd1, 16'sd1, 16'sd2, 1'b0});
      wait_drained();

      for (int ph = 0; ph < 8; ph++) begin
         if (ph < 4) begin
            c = fixed_cfgs[ph];
         end else begin
            c.normal_x = 16'($urandom_range(32768) - 16384);
            c.normal_y = 16'($urandom_range(32768) - 16384);
            c.normal_z = 16'($urandom_range(32768) - 16384);
            c.plane_offset = 16'($urandom_range(6000) - 3000);
            c.floor_limit = 16'(-$urandom_range(200));
            c.lift_mm = 10'($urandom_range(1023));
         end
         write_cfg(c);
         case (ph % 4)
            0: begin sender_idle_pct = 0;  rcv_stall_pct = 0;  end
            1: begin sender_idle_pct = 73; rcv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rcv_stall_pct = 73; end
            default: begin sender_idle_pct = 37; rcv_stall_pct = 37; end
         endcase
         for (int i = 0; i < 110; i++) add_point(rand_point());
         wait_drained();
      end

      if (err_count == 0 && expected_pts.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #3000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
